FILE: rtl/ssi3_pkg.sv
// shared types and constants for the 3d segment intersection pipeline
package ssi3_pkg;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int D_BITS     = COORD_BITS + 1;
  localparam int N_BITS     = 2 * D_BITS + 1;
  localparam int Q_BITS     = FRAC_BITS + 1;
  localparam int ST_BITS    = 2;
  localparam int DEN_BITS   = 2 * N_BITS + 2;
  localparam int W_BITS     = N_BITS;
  localparam int NUM_BITS   = W_BITS + N_BITS + 2;
  localparam int DIV_BITS   = DEN_BITS + 1;

  localparam logic [ST_BITS-1:0] ST_HIT          = 2'd0;
  localparam logic [ST_BITS-1:0] ST_NOT_COPLANAR = 2'd1;
  localparam logic [ST_BITS-1:0] ST_PARALLEL     = 2'd2;
  localparam logic [ST_BITS-1:0] ST_OUTSIDE      = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_BITS-1:0]     dvec_t [3];
  typedef logic signed [N_BITS-1:0]     nvec_t [3];
  typedef logic signed [W_BITS-1:0]     wvec_t [3];

  // one item in the divider stages
  typedef struct packed {
    logic [ST_BITS-1:0]  status;
    logic [DEN_BITS-1:0] den;
    logic [DIV_BITS-1:0] rem_s;
    logic [DIV_BITS-1:0] rem_t;
    logic [Q_BITS-1:0]   q_s;
    logic [Q_BITS-1:0]   q_t;
  } div_t;
endpackage

FILE: rtl/ssi3_geom.sv
// geometry stages: differences, cross products, dot products and range tests
module ssi3_geom (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vin,
  input  ssi3_pkg::coord_t        ao [3],
  input  ssi3_pkg::coord_t        ae [3],
  input  ssi3_pkg::coord_t        bo [3],
  input  ssi3_pkg::coord_t        be [3],
  output logic                    vout,
  output ssi3_pkg::div_t          dout
);
  import ssi3_pkg::*;

  // stage 1: differences
  dvec_t da_r, db_r, c_r;
  logic  v1_r;
  // stage 2: n = da x db
  nvec_t n_r;
  dvec_t da2_r, db2_r, c2_r;
  logic  v2_r;
  // stage 3: products with n, c x db, c x da
  logic signed [N_BITS+D_BITS:0] cn_r [3];
  logic signed [2*N_BITS-1:0]    nn_r [3];
  wvec_t cdb_r, cda_r;
  nvec_t n3_r;
  logic  v3_r;
  // stage 4: sums for den and the coplanarity test, products with n
  logic [DEN_BITS-1:0]            den_r;
  logic                           cop_r;
  logic signed [NUM_BITS-1:0]     ps_r [3];
  logic signed [NUM_BITS-1:0]     pt_r [3];
  logic  v4_r;
  // stage 5: numerator sums
  logic signed [NUM_BITS-1:0]     ns_r, nt_r;
  logic [DEN_BITS-1:0]            den5_r;
  logic                           cop5_r;
  logic                           v5_r;

  logic [ST_BITS-1:0] st_nxt;
  logic signed [NUM_BITS-1:0] cdot_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0; vout <= 1'b0;
    end else if (en) begin
      v1_r <= vin; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r; vout <= v5_r;
    end
  end

  assign cdot_w = NUM_BITS'(cn_r[0]) + NUM_BITS'(cn_r[1]) + NUM_BITS'(cn_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        da_r[k] <= D_BITS'(ae[k]) - D_BITS'(ao[k]);
        db_r[k] <= D_BITS'(be[k]) - D_BITS'(bo[k]);
        c_r[k]  <= D_BITS'(bo[k]) - D_BITS'(ao[k]);
      end
      n_r[0] <= N_BITS'(da_r[1] * db_r[2]) - N_BITS'(da_r[2] * db_r[1]);
      n_r[1] <= N_BITS'(da_r[2] * db_r[0]) - N_BITS'(da_r[0] * db_r[2]);
      n_r[2] <= N_BITS'(da_r[0] * db_r[1]) - N_BITS'(da_r[1] * db_r[0]);
      da2_r <= da_r; db2_r <= db_r; c2_r <= c_r;
      for (int k = 0; k < 3; k++) begin
        cn_r[k] <= (N_BITS+D_BITS+1)'(c2_r[k] * n_r[k]);
        nn_r[k] <= n_r[k] * n_r[k];
      end
      cdb_r[0] <= W_BITS'(c2_r[1] * db2_r[2]) - W_BITS'(c2_r[2] * db2_r[1]);
      cdb_r[1] <= W_BITS'(c2_r[2] * db2_r[0]) - W_BITS'(c2_r[0] * db2_r[2]);
      cdb_r[2] <= W_BITS'(c2_r[0] * db2_r[1]) - W_BITS'(c2_r[1] * db2_r[0]);
      cda_r[0] <= W_BITS'(c2_r[1] * da2_r[2]) - W_BITS'(c2_r[2] * da2_r[1]);
      cda_r[1] <= W_BITS'(c2_r[2] * da2_r[0]) - W_BITS'(c2_r[0] * da2_r[2]);
      cda_r[2] <= W_BITS'(c2_r[0] * da2_r[1]) - W_BITS'(c2_r[1] * da2_r[0]);
      n3_r <= n_r;
      den_r <= DEN_BITS'(unsigned'(nn_r[0])) + DEN_BITS'(unsigned'(nn_r[1]))
             + DEN_BITS'(unsigned'(nn_r[2]));
      cop_r <= (cdot_w == '0);
      for (int k = 0; k < 3; k++) begin
        ps_r[k] <= NUM_BITS'(cdb_r[k] * n3_r[k]);
        pt_r[k] <= NUM_BITS'(cda_r[k] * n3_r[k]);
      end
      ns_r <= ps_r[0] + ps_r[1] + ps_r[2];
      nt_r <= pt_r[0] + pt_r[1] + pt_r[2];
      den5_r <= den_r;
      cop5_r <= cop_r;
      dout.status <= st_nxt;
      dout.den    <= den5_r;
      dout.rem_s  <= DIV_BITS'(ns_r);
      dout.rem_t  <= DIV_BITS'(nt_r);
      dout.q_s    <= '0;
      dout.q_t    <= '0;
    end
  end

  always_comb begin
    if (!cop5_r) st_nxt = ST_NOT_COPLANAR;
    else if (den5_r == '0) st_nxt = ST_PARALLEL;
    else if (ns_r < 0 || ns_r > $signed({2'b0, den5_r}) || nt_r < 0
             || nt_r > $signed({2'b0, den5_r})) st_nxt = ST_OUTSIDE;
    else st_nxt = ST_HIT;
  end
endmodule

FILE: rtl/ssi3_div.sv
// restoring fraction divider, two quotient bits per stage (one in the last stage)
module ssi3_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vin,
  input  ssi3_pkg::div_t  din,
  output logic            vout,
  output logic [ssi3_pkg::ST_BITS-1:0] status,
  output logic [ssi3_pkg::Q_BITS-1:0]  s_q,
  output logic [ssi3_pkg::Q_BITS-1:0]  t_q
);
  import ssi3_pkg::*;

  localparam int STEPS  = Q_BITS;
  localparam int STAGES = (STEPS + 1) / 2;

  div_t st_r [STAGES];
  logic v_r  [STAGES];
  div_t st_nxt [STAGES];

  function automatic void step(input logic [DEN_BITS-1:0] den, inout logic [DIV_BITS-1:0] rem,
                               inout logic [Q_BITS-1:0] q, input logic first);
    logic [DIV_BITS-1:0] r;
    r = first ? rem : DIV_BITS'({rem, 1'b0});
    q = {q[Q_BITS-2:0], 1'b0};
    if (r >= DIV_BITS'(den)) begin
      r = r - DIV_BITS'(den);
      q[0] = 1'b1;
    end
    rem = r;
  endfunction

  always_comb begin
    st_nxt[0] = din;
    for (int g = 1; g < STAGES; g++) st_nxt[g] = st_r[g-1];
    for (int g = 0; g < STAGES; g++) begin
      for (int j = 0; j < 2; j++) begin
        if (2*g + j < STEPS) begin
          step(st_nxt[g].den, st_nxt[g].rem_s, st_nxt[g].q_s, (2*g + j) == 0);
          step(st_nxt[g].den, st_nxt[g].rem_t, st_nxt[g].q_t, (2*g + j) == 0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < STAGES; g++) v_r[g] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vin;
      for (int g = 1; g < STAGES; g++) v_r[g] <= v_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < STAGES; g++) st_r[g] <= st_nxt[g];
    end
  end

  assign vout   = v_r[STAGES-1];
  assign status = st_r[STAGES-1].status;
  assign s_q    = (st_r[STAGES-1].status == ST_HIT) ? st_r[STAGES-1].q_s : '0;
  assign t_q    = (st_r[STAGES-1].status == ST_HIT) ? st_r[STAGES-1].q_t : '0;
endmodule

FILE: rtl/segment_segment_intersect_3d.sv
// top level: 3d segment intersection pipeline with output register
// Accepts one segment pair per cycle while not stalled and returns one result per pair. The
// pipeline has 6 geometry stages, 9 divider stages and the output register; the whole
// pipeline advances together and holds while the output register is full and not taken.
module segment_segment_intersect_3d (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [11:0] in_a_orig_x,
  input  logic signed [11:0] in_a_orig_y,
  input  logic signed [11:0] in_a_orig_z,
  input  logic signed [11:0] in_a_end_x,
  input  logic signed [11:0] in_a_end_y,
  input  logic signed [11:0] in_a_end_z,
  input  logic signed [11:0] in_b_orig_x,
  input  logic signed [11:0] in_b_orig_y,
  input  logic signed [11:0] in_b_orig_z,
  input  logic signed [11:0] in_b_end_x,
  input  logic signed [11:0] in_b_end_y,
  input  logic signed [11:0] in_b_end_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0]  out_status,
  output logic [16:0] out_s_param,
  output logic [16:0] out_t_param
);
  import ssi3_pkg::*;

  logic en, gv, dv;
  div_t gd;
  coord_t ao [3], ae [3], bo [3], be [3];
  logic [ST_BITS-1:0] st_w;
  logic [Q_BITS-1:0]  s_w, t_w;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign ao = '{in_a_orig_x, in_a_orig_y, in_a_orig_z};
  assign ae = '{in_a_end_x, in_a_end_y, in_a_end_z};
  assign bo = '{in_b_orig_x, in_b_orig_y, in_b_orig_z};
  assign be = '{in_b_end_x, in_b_end_y, in_b_end_z};

  ssi3_geom u_geom (.clk, .rst_n, .en, .vin(in_valid), .ao, .ae, .bo, .be,
                    .vout(gv), .dout(gd));
  ssi3_div u_div (.clk, .rst_n, .en, .vin(gv), .din(gd), .vout(dv), .status(st_w),
                  .s_q(s_w), .t_q(t_w));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= dv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status  <= st_w;
      out_s_param <= s_w;
      out_t_param <= t_w;
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed under stall");
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_s_param == '0 && out_t_param == '0)
    else $error("nonzero parameter without hit");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HIT |-> out_s_param <= 17'h10000 && out_t_param <= 17'h10000)
    else $error("parameter above one");
`endif
endmodule

FILE: tb/testbench.sv
// testbench for the 3d segment intersection pipeline: predicted results checked in order
`timescale 1ns / 1ps

module testbench;
  import ssi3_pkg::*;

  typedef logic [11:0][11:0] seg_pair_t;
  typedef struct {
    logic [ST_BITS-1:0] status;
    logic [Q_BITS-1:0]  s_param;
    logic [Q_BITS-1:0]  t_param;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [16:0] out_s_param;
  logic [16:0] out_t_param;
  seg_pair_t in_pair = '0;

  seg_pair_t pending_pairs[$];
  isect_t expected_isects[$];
  int errors = 0;
  bit fill_done = 1'b0;
  bit taken = 1'b0;

  segment_segment_intersect_3d u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_orig_x(in_pair[0]), .in_a_orig_y(in_pair[1]), .in_a_orig_z(in_pair[2]),
    .in_a_end_x(in_pair[3]), .in_a_end_y(in_pair[4]), .in_a_end_z(in_pair[5]),
    .in_b_orig_x(in_pair[6]), .in_b_orig_y(in_pair[7]), .in_b_orig_z(in_pair[8]),
    .in_b_end_x(in_pair[9]), .in_b_end_y(in_pair[10]), .in_b_end_z(in_pair[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_s_param(out_s_param), .out_t_param(out_t_param)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot_prod(input longint a[3], input longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // restoring division, num <= den
  function automatic logic [Q_BITS-1:0] to_fraction(input longint num, input longint den);
    longint q;
    longint rem;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem -= den;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem <<< 1;
      q = q <<< 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q[Q_BITS-1:0];
  endfunction

  function automatic isect_t predict_isect(input seg_pair_t p);
    longint ao[3], ae[3], bo[3], be[3];
    longint da[3], db[3], c[3], n[3], cdb[3], cda[3];
    longint den, ns, nt;
    isect_t r;
    for (int k = 0; k < 3; k++) begin
      ao[k] = longint'($signed(p[k]));
      ae[k] = longint'($signed(p[3 + k]));
      bo[k] = longint'($signed(p[6 + k]));
      be[k] = longint'($signed(p[9 + k]));
      da[k] = ae[k] - ao[k];
      db[k] = be[k] - bo[k];
      c[k] = bo[k] - ao[k];
    end
    cross_prod(da, db, n);
    r.s_param = '0;
    r.t_param = '0;
    if (dot_prod(c, n) != 0) begin
      r.status = ST_NOT_COPLANAR;
      return r;
    end
    den = dot_prod(n, n);
    if (den == 0) begin
      r.status = ST_PARALLEL;
      return r;
    end
    cross_prod(c, db, cdb);
    cross_prod(c, da, cda);
    ns = dot_prod(cdb, n);
    nt = dot_prod(cda, n);
    if (ns < 0 || ns > den || nt < 0 || nt > den) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    r.status = ST_HIT;
    r.s_param = to_fraction(ns, den);
    r.t_param = to_fraction(nt, den);
    return r;
  endfunction

  task automatic add_pair(input int v[12]);
    seg_pair_t p;
    for (int k = 0; k < 12; k++) p[k] = v[k][11:0];
    pending_pairs.push_back(p);
  endtask

  function automatic int rnd(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  // stimulus
  initial begin
    int v[12];
    int o[3], u[3], w[3], kind, m;
    add_pair('{-10, 0, 0, 10, 0, 0, 0, -10, 0, 0, 10, 0});
    add_pair('{0, 0, 0, 4, 0, 0, 4, 0, 0, 4, 4, 0});
    add_pair('{0, 0, 0, 1, 0, 0, 5, -1, 0, 5, 1, 0});
    add_pair('{-10, 0, 0, 10, 0, 0, 0, -1, 5, 0, 1, 5});
    add_pair('{0, 0, 0, 5, 0, 0, 0, 3, 0, 5, 3, 0});
    add_pair('{0, 0, 0, 5, 0, 0, 2, 0, 0, 8, 0, 0});
    add_pair('{3, 3, 3, 3, 3, 3, -7, 2, 9, 4, -1, 0});
    add_pair('{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5});
    add_pair('{-2048, -2048, -2048, 2047, 2047, 2047, -2048, 2047, -2048, 2047, -2048, 2047});
    add_pair('{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047});
    add_pair('{-2048, -2048, -2048, -2048, -2048, -2048,
               -2048, -2048, -2048, -2048, -2048, -2048});
    add_pair('{-2048, 0, 0, 2047, 0, 0, 0, 1, 0, 0, 2047, 0});
    add_pair('{0, 0, 0, 7, 3, 1, 0, 0, 0, -2, 5, 9});
    add_pair('{-2048, 2047, 0, 2047, -2048, 0, 2047, 2047, -5, -2048, -2048, 7});
    for (int i = 0; i < 1550; i++) begin
      kind = rnd(0, 19);
      for (int k = 0; k < 3; k++) begin
        o[k] = rnd(-400, 400);
        u[k] = rnd(-100, 100);
        w[k] = rnd(-100, 100);
      end
      if (kind < 11) begin
        // four points in one plane
        for (int j = 0; j < 4; j++) begin
          int a, b;
          a = rnd(-8, 8);
          b = rnd(-8, 8);
          for (int k = 0; k < 3; k++) v[3 * j + k] = o[k] + a * u[k] + b * w[k];
        end
      end else if (kind < 14) begin
        // parallel or collinear, sometimes zero length
        m = rnd(-2, 2);
        for (int k = 0; k < 3; k++) begin
          v[k] = o[k];
          v[3 + k] = o[k] + 3 * u[k];
          v[6 + k] = (kind == 13) ? o[k] + rnd(-2, 2) * u[k] : o[k] + w[k];
          v[9 + k] = v[6 + k] + m * u[k];
        end
      end else begin
        for (int k = 0; k < 12; k++) v[k] = rnd(0, 4095);
        if (kind == 14) for (int k = 0; k < 3; k++) v[3 + k] = v[k];
      end
      add_pair(v);
    end
    fill_done = 1'b1;
  end

  // reset
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // request acceptance and prediction
  always @(posedge clk) begin
    taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_isects.push_back(predict_isect(in_pair));
  end

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (gap_left > 0 || pending_pairs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_pair <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = rnd(1, 30);
          gap_left = ($urandom_range(3) == 0) ? 0 : rnd(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver stall pattern
  int rdy_cnt = 0;
  always @(negedge clk) begin
    rdy_cnt++;
    case ((rdy_cnt / 250) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= (rdy_cnt % 7) < 3;
      default: out_ready <= $urandom_range(3) != 0;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_isects.size() == 0) begin
        $error("unexpected result: status %0d", out_status);
        errors++;
      end else begin
        isect_t e;
        e = expected_isects.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_s_param !== e.s_param) begin
          $error("s_param: expected %0d, got %0d", e.s_param, out_s_param);
          errors++;
        end
        if (out_t_param !== e.t_param) begin
          $error("t_param: expected %0d, got %0d", e.t_param, out_t_param);
          errors++;
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (!fill_done || pending_pairs.size() != 0 || in_valid ||
           expected_isects.size() != 0);
    repeat (40) @(posedge clk);
    if (expected_isects.size() != 0) errors++;
    if (errors == 0) begin
      $display("segment_segment_intersect_3d test passed");
    end else begin
      $display("segment_segment_intersect_3d test failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("segment_segment_intersect_3d test failed");
    $finish;
  end
endmodule

FILE: segment_segment_intersect_3d.f
rtl/ssi3_pkg.sv
rtl/ssi3_geom.sv
rtl/ssi3_div.sv
rtl/segment_segment_intersect_3d.sv
tb/testbench.sv
